>>> src/l4plp_pkg.sv
`timescale 1ns / 1ps
// package for the l4 payload length parser
// holds field widths, header offsets and protocol codes; no dependencies

package l4plp_pkg;

    // payload widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int POS_W  = 7;
    localparam int FLEN_W = POS_W + 1;

    typedef logic [POS_W-1:0]  t_byte_pos;
    typedef logic [FLEN_W-1:0] t_frame_len;
    typedef logic [LEN_W-1:0]  t_len;

    // ethertypes and protocol numbers
    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_IPV6  = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    // header sizes
    localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
    localparam t_len       UDP_HDR_BYTES = 16'd8;

    // byte positions within the frame
    localparam t_byte_pos POS_MAX         = 7'd127;
    localparam t_byte_pos POS_ETYPE_HI    = 7'd12;
    localparam t_byte_pos POS_ETYPE_LO    = 7'd13;
    localparam t_byte_pos POS_IP_START    = 7'd14;
    localparam t_byte_pos POS_V4_LEN_HI   = 7'd16;
    localparam t_byte_pos POS_V4_LEN_LO   = 7'd17;
    localparam t_byte_pos POS_V4_PROTO    = 7'd23;
    localparam t_byte_pos POS_V6_LEN_HI   = 7'd18;
    localparam t_byte_pos POS_V6_LEN_LO   = 7'd19;
    localparam t_byte_pos POS_V6_NEXT     = 7'd20;
    localparam t_byte_pos POS_V6_TCP_OFF  = 7'd66;
    // ethernet header plus tcp byte 12, before the ipv4 header length
    localparam t_frame_len V4_TCP_OFF_BASE = 8'd26;

    // minimum frame lengths for a usable result
    localparam t_frame_len LEN_MIN_ETH = 8'd14;
    localparam t_frame_len LEN_MIN_V4  = 8'd34;
    localparam t_frame_len LEN_MIN_V6  = 8'd54;

endpackage

>>> src/l4plp_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the l4 payload length parser
// depends on l4plp_pkg for payload widths

interface l4plp_in_if;
    import l4plp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface l4plp_out_if;
    import l4plp_pkg::*;

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] l4_len;

    modport source (output valid, output l4_len, input ready);
    modport sink   (input valid, input l4_len, output ready);
endinterface

>>> src/l4_payload_length_parser.sv
`timescale 1ns / 1ps
// Streaming TCP/UDP payload length parser. Takes an Ethernet frame one byte per clock
// and one transaction per cycle, back to back, for as long as results are taken; the
// per-byte header capture runs in the cycle a byte is accepted. Once its last byte
// is accepted, a frame's result passes through a snapshot register holding the
// captured headers and then a result register holding the computed length, so the
// next frame streams in while a result waits. IPv4 and IPv6 without VLAN tags or
// extension headers; anything else, or a truncated frame, gives a length of 0.
// depends on l4plp_pkg and l4plp_if

module l4_payload_length_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    l4plp_in_if.sink           i_in,
    l4plp_out_if.source        o_out
);
    import l4plp_pkg::*;

    // header capture state
    t_byte_pos    r_pos;
    logic [15:0]  r_ether_type;
    logic [3:0]   r_ihl;
    t_len         r_len_field;
    logic [7:0]   r_proto;
    logic [3:0]   r_toff;
    logic         r_toff_seen;

    logic [15:0]  n_ether_type;
    logic [3:0]   n_ihl;
    t_len         n_len_field;
    logic [7:0]   n_proto;
    logic [3:0]   n_toff;
    logic         n_toff_seen;

    // finished frame snapshot
    logic         r_f_valid;
    logic         r_f_v4;
    logic         r_f_v6;
    t_frame_len   r_f_len;
    logic [3:0]   r_f_ihl;
    t_len         r_f_len_field;
    logic [7:0]   r_f_proto;
    logic [3:0]   r_f_toff;
    logic         r_f_toff_seen;

    // result register
    logic         r_o_valid;
    t_len         r_o_len;

    logic         out_take;
    logic         snap_move;
    logic         in_acc;
    logic [7:0]   b;
    logic         in_v4;
    logic         in_v6;
    t_frame_len   v4_tcp_pos;

    logic [5:0]   ihl_bytes;
    logic [5:0]   doff_bytes;
    t_len         seg_total;
    t_len         l4_pay;
    logic         hdr_ok;
    t_len         n_o_len;

    // pipeline flow control
    assign out_take    = !r_o_valid || o_out.ready;
    assign snap_move   = r_f_valid && out_take;
    assign i_in.ready  = !r_f_valid || out_take;
    assign in_acc      = i_in.valid && i_in.ready;
    assign b           = i_in.frame_byte;

    // capture of header fields at their byte positions
    always_comb begin
        n_ether_type = r_ether_type;
        n_ihl        = r_ihl;
        n_len_field  = r_len_field;
        n_proto      = r_proto;
        n_toff       = r_toff;
        n_toff_seen  = r_toff_seen;

        if (r_pos == POS_ETYPE_HI) begin
            n_ether_type[15:8] = b;
        end
        if (r_pos == POS_ETYPE_LO) begin
            n_ether_type[7:0] = b;
        end

        in_v4 = (n_ether_type == ETH_IPV4) && (r_pos >= POS_IP_START);
        in_v6 = (n_ether_type == ETH_IPV6) && (r_pos >= POS_IP_START);

        if (in_v4 && r_pos == POS_IP_START) begin
            n_ihl = b[3:0];
        end
        v4_tcp_pos = V4_TCP_OFF_BASE + {2'b00, n_ihl, 2'b00};

        if (in_v4) begin
            if (r_pos == POS_V4_LEN_HI) n_len_field[15:8] = b;
            if (r_pos == POS_V4_LEN_LO) n_len_field[7:0]  = b;
            if (r_pos == POS_V4_PROTO)  n_proto           = b;
            if (r_pos > POS_IP_START && {1'b0, r_pos} == v4_tcp_pos) begin
                n_toff      = b[7:4];
                n_toff_seen = 1'b1;
            end
        end else if (in_v6) begin
            if (r_pos == POS_V6_LEN_HI) n_len_field[15:8] = b;
            if (r_pos == POS_V6_LEN_LO) n_len_field[7:0]  = b;
            if (r_pos == POS_V6_NEXT)   n_proto           = b;
            if (r_pos == POS_V6_TCP_OFF) begin
                n_toff      = b[7:4];
                n_toff_seen = 1'b1;
            end
        end
    end

    // capture state, cleared after each last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_ether_type <= '0;
            r_ihl        <= '0;
            r_len_field  <= '0;
            r_proto      <= '0;
            r_toff       <= '0;
            r_toff_seen  <= 1'b0;
        end else if (in_acc) begin
            if (i_in.frame_last) begin
                r_pos        <= '0;
                r_ether_type <= '0;
                r_ihl        <= '0;
                r_len_field  <= '0;
                r_proto      <= '0;
                r_toff       <= '0;
                r_toff_seen  <= 1'b0;
            end else begin
                if (r_pos != POS_MAX) begin
                    r_pos <= r_pos + 7'd1;
                end
                r_ether_type <= n_ether_type;
                r_ihl        <= n_ihl;
                r_len_field  <= n_len_field;
                r_proto      <= n_proto;
                r_toff       <= n_toff;
                r_toff_seen  <= n_toff_seen;
            end
        end
    end

    // snapshot valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (in_acc && i_in.frame_last) begin
            r_f_valid <= 1'b1;
        end else if (snap_move) begin
            r_f_valid <= 1'b0;
        end
    end

    // snapshot payload on the last byte
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.frame_last) begin
            r_f_v4        <= (n_ether_type == ETH_IPV4);
            r_f_v6        <= (n_ether_type == ETH_IPV6);
            r_f_len       <= {1'b0, r_pos} + 8'd1;
            r_f_ihl       <= n_ihl;
            r_f_len_field <= n_len_field;
            r_f_proto     <= n_proto;
            r_f_toff      <= n_toff;
            r_f_toff_seen <= n_toff_seen;
        end
    end

    // payload length from the snapshot
    always_comb begin
        ihl_bytes  = {r_f_ihl, 2'b00};
        doff_bytes = {r_f_toff, 2'b00};

        if (r_f_v4) begin
            seg_total = (r_f_len_field > {10'd0, ihl_bytes})
                      ? r_f_len_field - {10'd0, ihl_bytes} : '0;
        end else begin
            seg_total = r_f_len_field;
        end

        if (r_f_proto == PROTO_TCP) begin
            if (r_f_toff_seen && r_f_toff >= MIN_HDR_WORDS
                    && seg_total > {10'd0, doff_bytes}) begin
                l4_pay = seg_total - {10'd0, doff_bytes};
            end else begin
                l4_pay = '0;
            end
        end else if (r_f_proto == PROTO_UDP) begin
            l4_pay = (seg_total > UDP_HDR_BYTES) ? seg_total - UDP_HDR_BYTES : '0;
        end else begin
            l4_pay = '0;
        end

        hdr_ok  = (r_f_v4 && r_f_len >= LEN_MIN_V4 && r_f_ihl >= MIN_HDR_WORDS)
               || (r_f_v6 && r_f_len >= LEN_MIN_V6);
        n_o_len = (hdr_ok && r_f_len >= LEN_MIN_ETH) ? l4_pay : '0;
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_take) begin
            r_o_valid <= r_f_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (snap_move) begin
            r_o_len <= n_o_len;
        end
    end

    assign o_out.valid  = r_o_valid;
    assign o_out.l4_len = r_o_len;

endmodule

>>> src/l4plp_checker.sv
`timescale 1ns / 1ps
// port-level checker for the l4 payload length parser, with its bind
// depends on l4plp_pkg and the top level l4_payload_length_parser

module l4plp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_last,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [l4plp_pkg::LEN_W-1:0] i_out_len
);
    import l4plp_pkg::*;

    logic       in_last_acc;
    logic       out_acc;
    logic [1:0] r_pending;

    assign in_last_acc = i_in_valid && i_in_ready && i_in_last;
    assign out_acc     = i_out_valid && i_out_ready;

    // frames finished but results not yet taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {1'b0, in_last_acc} - {1'b0, out_acc};
        end
    end

    // stalled result holds its length
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_len)))
        else $error("result changed while stalled");

    // no result without a finished frame
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != 2'd0))
        else $error("result without a last byte");

    // at most two frames in flight
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("more than two results in flight");

    // on an empty pipe the result goes from the last byte through the snapshot, then the result register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_last_acc && r_pending == 2'd0) |=> ##1 i_out_valid)
        else $error("result late on an empty pipe");

endmodule

bind l4_payload_length_parser l4plp_checker u_l4plp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.frame_last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_len   (o_out.l4_len)
);
